// ===== rtl/core/wrl_pkg.sv =====
// wrl_pkg: shared types and constants for the weighted readout low-pass block.
// No dependencies; imported by wrl_ctrl, wrl_dp and weighted_readout_lowpass_top.
package wrl_pkg;

  localparam int VAL_W   = 32;
  localparam int IDX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int SUM_W   = 48;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int FPROD_W = COEF_W + 1 + VAL_W;
  localparam int FACC_W  = FPROD_W + 1;
  localparam int FRAC_W  = 16;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'd1;

  localparam logic CMD_WEIGHT   = 1'b0;
  localparam logic CMD_ACTIVITY = 1'b1;

  localparam logic [COEF_W-1:0] DECAY_RESET = 16'd59299;
  localparam logic [COEF_W-1:0] GAIN_RESET  = 16'd6237;

  typedef struct packed {
    logic capture;
    logic mul_en;
    logic acc_en;
    logic fmul_en;
    logic fout_en;
  } ctrl_cmd_t;

endpackage

// ===== rtl/core/weighted_readout_lowpass_top.sv =====
// weighted_readout_lowpass_top: weighted-sum readout followed by a one-pole low-pass.
// Depends on wrl_pkg, wrl_ctrl and wrl_dp.
//
// Usage: requests on the in_ channel either load a weight (in_command = 0) or
// present one activity element (in_command = 1) that is multiplied by the
// stored weight at in_element_index and added to a saturating 48-bit Q32.16 sum.
// An activity request with in_last_element set updates the filter
// (filtered = decay*filtered + gain*sum), clears the sum and produces one
// result request on the out_ channel; no other request produces a result.
// A weight request leaves the block ready for the next request; a non-final
// activity request passes through table read and multiply (S_MUL), with the
// accumulate overlapped with the next request. A final element holds the input
// through the multiply, accumulate, filter multiply and filter update steps
// (S_MUL, S_ACC, S_FMUL, S_FOUT); its result then goes into the output register.
// The result sits in an output register; if the receiver stalls, the block
// keeps taking requests and only a further final element waits for it.
// cfg_ writes (index 0 decay, index 1 gain, Q0.16) are always accepted and
// should be issued only while the block is idle.
// Reset clears the sum and filter state and restores the default
// coefficients; the weight table is undefined until written.
module weighted_readout_lowpass_top #(
  parameter int MAX_INPUTS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic        [wrl_pkg::IDX_W-1:0]      in_element_index,
  input  logic signed [wrl_pkg::VAL_W-1:0]      in_element_value,
  input  logic                                  in_last_element,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wrl_pkg::VAL_W-1:0]      out_filtered_value,
  output logic signed [wrl_pkg::VAL_W-1:0]      out_weighted_sum,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [wrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [wrl_pkg::COEF_W-1:0]     cfg_data
);
  import wrl_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  wrl_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cmd             (cmd)
  );

  wrl_dp #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_command         (in_command),
    .in_element_index   (in_element_index),
    .in_element_value   (in_element_value),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_filtered_value (out_filtered_value),
    .out_weighted_sum   (out_weighted_sum)
  );

endmodule

// ===== rtl/core/wrl_ctrl.sv =====
// wrl_ctrl: sequencing state machine for the weighted readout low-pass block.
// Depends on wrl_pkg (ctrl_cmd_t, command codes); drives wrl_dp.
module wrl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic                in_last_element,
  output logic                out_valid,
  input  logic                out_ready,
  output wrl_pkg::ctrl_cmd_t  cmd
);
  import wrl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_FMUL = 3'd3;
  localparam logic [2:0] S_FOUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    last_nxt    = last_r;
    pend_nxt    = 1'b0;
    cmd         = '0;
    cmd.capture = accept;
    cmd.acc_en  = pend_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_command == CMD_ACTIVITY) begin
          state_nxt = S_MUL;
          last_nxt  = in_last_element;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (last_r) begin
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_IDLE;
          pend_nxt  = 1'b1;
        end
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_FMUL;
      end
      S_FMUL: begin
        cmd.fmul_en = 1'b1;
        state_nxt   = S_FOUT;
      end
      S_FOUT: begin
        if (out_free) begin
          cmd.fout_en = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fout_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/wrl_dp.sv =====
// wrl_dp: weight memory, multiply-accumulate and one-pole filter datapath.
// Depends on wrl_pkg; steered by ctrl_cmd_t from wrl_ctrl.
module wrl_dp #(
  parameter int MAX_INPUTS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wrl_pkg::ctrl_cmd_t                  cmd,
  input  logic                                in_command,
  input  logic        [wrl_pkg::IDX_W-1:0]    in_element_index,
  input  logic signed [wrl_pkg::VAL_W-1:0]    in_element_value,
  input  logic                                cfg_we,
  input  logic        [wrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [wrl_pkg::COEF_W-1:0]   cfg_data,
  output logic signed [wrl_pkg::VAL_W-1:0]    out_filtered_value,
  output logic signed [wrl_pkg::VAL_W-1:0]    out_weighted_sum
);
  import wrl_pkg::*;

  localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] W32_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] W32_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic signed [VAL_W-1:0]   mem [MAX_INPUTS];

  logic        [XW-1:0]      idx_x;
  logic        [AW-1:0]      addr;
  logic                      in_range;

  logic signed [VAL_W-1:0]   wt_r;
  logic signed [VAL_W-1:0]   act_r;
  logic                      in_range_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [VAL_W-1:0]   filt_r;
  logic        [COEF_W-1:0]  decay_r;
  logic        [COEF_W-1:0]  gain_r;
  logic signed [FPROD_W-1:0] dprod_r;
  logic signed [FPROD_W-1:0] gprod_r;
  logic signed [VAL_W-1:0]   sum32_r;
  logic signed [VAL_W-1:0]   out_filt_r;
  logic signed [VAL_W-1:0]   out_sum_r;

  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [SUM_W-1:0]   addend;
  logic signed [SUM_W:0]     sum_ext;
  logic signed [VAL_W-1:0]   sum32;
  logic signed [FACC_W-1:0]  facc;
  logic signed [FACC_W-FRAC_W-1:0] frnd;
  logic signed [VAL_W-1:0]   filt_new;

  assign idx_x    = XW'(in_element_index);
  assign addr     = idx_x[AW-1:0];
  assign in_range = (32'(in_element_index) < MAX_INPUTS);

  // weight table: write on a weight request, registered read on an activity request (both only for an in-range index)
  always_ff @(posedge clk) begin
    if (cmd.capture && in_range) begin
      if (in_command == CMD_WEIGHT) begin
        mem[addr] <= in_element_value;
      end else begin
        wt_r <= mem[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r      <= in_element_value;
      in_range_r <= in_range;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(wt_r) * PROD_W'(act_r);
    end
  end

  // round half up to 16 fraction bits (Q32.16 addend), then saturating accumulate
  assign prod_rnd = (prod_r + PROD_W'(32768)) >>> FRAC_W;
  assign addend   = in_range_r ? prod_rnd[SUM_W-1:0] : '0;
  assign sum_ext  = {sum_r[SUM_W-1], sum_r} + {addend[SUM_W-1], addend};

  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_nxt = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_ext[SUM_W-1:0];
    end
  end

  always_comb begin
    if (sum_r > SUM_W'(W32_MAX)) begin
      sum32 = W32_MAX;
    end else if (sum_r < SUM_W'(W32_MIN)) begin
      sum32 = W32_MIN;
    end else begin
      sum32 = sum_r[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fmul_en) begin
      dprod_r <= FPROD_W'($signed({1'b0, decay_r})) * FPROD_W'(filt_r);
      gprod_r <= FPROD_W'($signed({1'b0, gain_r})) * FPROD_W'(sum32);
      sum32_r <= sum32;
    end
  end

  assign facc = {dprod_r[FPROD_W-1], dprod_r} + {gprod_r[FPROD_W-1], gprod_r}
                + FACC_W'(32768);
  assign frnd = facc[FACC_W-1:FRAC_W];

  always_comb begin
    if (frnd > (FACC_W-FRAC_W)'(W32_MAX)) begin
      filt_new = W32_MAX;
    end else if (frnd < (FACC_W-FRAC_W)'(W32_MIN)) begin
      filt_new = W32_MIN;
    end else begin
      filt_new = frnd[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fout_en) begin
      out_filt_r <= filt_new;
      out_sum_r  <= sum32_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      filt_r  <= '0;
      decay_r <= DECAY_RESET;
      gain_r  <= GAIN_RESET;
    end else begin
      if (cmd.fout_en) begin
        sum_r  <= '0;
        filt_r <= filt_new;
      end else if (cmd.acc_en) begin
        sum_r <= sum_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DECAY: decay_r <= cfg_data;
          REG_GAIN:  gain_r  <= cfg_data;
          default:   ;
        endcase
      end
    end
  end

  assign out_filtered_value = out_filt_r;
  assign out_weighted_sum   = out_sum_r;

endmodule

// ===== tb/sv/weighted_readout_lowpass_top_tb.sv =====
// weighted_readout_lowpass_top_tb: self-checking bench for the weighted readout low-pass block.
// Drives weight/activity requests and coefficient writes, predicts each readout and checks it.
// Depends on wrl_pkg and weighted_readout_lowpass_top.
module weighted_readout_lowpass_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wrl_pkg::*;

  localparam int     TABLE_DEPTH = 256;
  localparam int     SETTLE      = 12;
  localparam int     CYCLE_LIMIT = 400000;
  localparam longint SUM_HI      = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO      = -SUM_HI - 1;
  localparam longint W32_HI      = 64'sh0000_0000_7FFF_FFFF;
  localparam longint W32_LO      = -W32_HI - 1;
  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [VAL_W-1:0] filtered;
    logic signed [VAL_W-1:0] wsum;
  } readout_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_command = CMD_WEIGHT;
  logic [IDX_W-1:0]         in_element_index = '0;
  logic signed [VAL_W-1:0]  in_element_value = '0;
  logic                     in_last_element = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [VAL_W-1:0]  out_filtered_value;
  logic signed [VAL_W-1:0]  out_weighted_sum;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_DECAY;
  logic [COEF_W-1:0]        cfg_data = '0;

  // predictor state
  logic signed [VAL_W-1:0]  weight_mem [TABLE_DEPTH];
  longint                   acc_sum = 0;
  logic signed [VAL_W-1:0]  filt_state = '0;
  logic [COEF_W-1:0]        decay_q = DECAY_RESET;
  logic [COEF_W-1:0]        gain_q = GAIN_RESET;
  readout_t                 pending_readouts[$];

  int in_gap_pct = 16;
  int out_stall_pct = 77;
  int failures = 0;
  int weight_reqs = 0;
  int activity_reqs = 0;
  int readouts_checked = 0;
  int coef_writes = 0;
  int cycle_count = 0;

  weighted_readout_lowpass_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_element_index(in_element_index), .in_element_value(in_element_value),
    .in_last_element(in_last_element),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_filtered_value(out_filtered_value), .out_weighted_sum(out_weighted_sum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[weighted_readout_lowpass_top] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // readout checker
  always @(posedge clk) begin
    readout_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readouts.size() == 0) begin
        $error("readout with nothing pending: filtered_value %0d weighted_sum %0d",
               out_filtered_value, out_weighted_sum);
        failures++;
      end else begin
        exp_r = pending_readouts.pop_front();
        readouts_checked++;
        if (out_filtered_value !== exp_r.filtered) begin
          $error("filtered_value: expected %0d, got %0d", exp_r.filtered, out_filtered_value);
          failures++;
        end
        if (out_weighted_sum !== exp_r.wsum) begin
          $error("weighted_sum: expected %0d, got %0d", exp_r.wsum, out_weighted_sum);
          failures++;
        end
      end
    end
  end

  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> FRAC_W;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic predict_readout(input logic cmd, input logic [IDX_W-1:0] idx,
                                 input logic signed [VAL_W-1:0] val, input logic last);
    longint   prod;
    longint   sum32;
    longint   mix;
    longint   d;
    longint   g;
    longint   f;
    readout_t r;
    if (cmd == CMD_WEIGHT) begin
      if (int'(idx) < TABLE_DEPTH) weight_mem[idx] = val;
      return;
    end
    if (int'(idx) < TABLE_DEPTH) begin
      prod = longint'(weight_mem[idx]) * longint'(val);
      acc_sum = clamp_to(acc_sum + round_q16(prod), SUM_LO, SUM_HI);
    end
    if (!last) return;
    sum32 = clamp_to(acc_sum, W32_LO, W32_HI);
    d = decay_q;
    g = gain_q;
    f = filt_state;
    mix = d * f + g * sum32;
    filt_state = VAL_W'(clamp_to(round_q16(mix), W32_LO, W32_HI));
    acc_sum = 0;
    r.filtered = filt_state;
    r.wsum = VAL_W'(sum32);
    pending_readouts.push_back(r);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_q16();
    int v;
    case ($urandom_range(9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2, 3, 4: v = int'($urandom_range(18'h3FFFF)) - 131072;
      5, 6: begin
        v = 65536 + int'($urandom_range(16383)) - 8192;
        if ($urandom_range(1) == 1) v = -v;
      end
      7, 8: v = $urandom();
      default: v = int'($urandom_range(4)) - 2;
    endcase
    return v;
  endfunction

  task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_element_index <= idx;
    in_element_value <= val;
    in_last_element  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_readout(cmd, idx, val, last);
    if (cmd == CMD_WEIGHT) weight_reqs++;
    else activity_reqs++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_DECAY) decay_q = val;
    else if (idx == REG_GAIN) gain_q = val;
    coef_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // rounding at both signs, 48-bit and 32-bit saturation, last flag on a weight write
  task automatic test_rounding_and_saturation();
    send_request(CMD_WEIGHT, 8'd0, 32'sh0001_0000, 1'b0);
    send_request(CMD_WEIGHT, 8'd1, 32'sh0000_0001, 1'b0);
    send_request(CMD_WEIGHT, 8'd255, Q_MAX, 1'b0);
    send_request(CMD_WEIGHT, 8'd128, Q_MIN, 1'b1);
    send_request(CMD_ACTIVITY, 8'd0, 32'sh0003_0000, 1'b1);
    send_request(CMD_ACTIVITY, 8'd1, 32'sh0000_8000, 1'b0);
    send_request(CMD_ACTIVITY, 8'd1, 32'shFFFF_8000, 1'b0);
    send_request(CMD_ACTIVITY, 8'd1, 32'sh0000_7FFF, 1'b1);
    repeat (2) send_request(CMD_ACTIVITY, 8'd255, Q_MAX, 1'b0);
    send_request(CMD_ACTIVITY, 8'd255, Q_MAX, 1'b1);
    repeat (2) send_request(CMD_ACTIVITY, 8'd255, Q_MIN, 1'b0);
    send_request(CMD_ACTIVITY, 8'd255, Q_MIN, 1'b1);
    send_request(CMD_ACTIVITY, 8'd128, Q_MIN, 1'b1);
    send_request(CMD_WEIGHT, 8'd0, 32'shFFFF_0000, 1'b0);
    send_request(CMD_ACTIVITY, 8'd0, Q_MAX, 1'b1);
    send_request(CMD_ACTIVITY, 8'd0, 32'sh0000_0000, 1'b1);
  endtask

  // zero and full-scale coefficients, filter saturation both ways
  task automatic test_coefficient_extremes();
    drain_results();
    write_coef(REG_DECAY, 16'h0000);
    write_coef(REG_GAIN, 16'hFFFF);
    send_request(CMD_ACTIVITY, 8'd0, 32'sh0123_4567, 1'b1);
    drain_results();
    write_coef(REG_DECAY, 16'hFFFF);
    repeat (2) send_request(CMD_ACTIVITY, 8'd255, Q_MAX, 1'b1);
    repeat (3) send_request(CMD_ACTIVITY, 8'd255, Q_MIN, 1'b1);
    drain_results();
    write_coef(REG_GAIN, 16'h0000);
    send_request(CMD_ACTIVITY, 8'd255, Q_MAX, 1'b1);
    drain_results();
    write_coef(REG_DECAY, 16'h0000);
    send_request(CMD_ACTIVITY, 8'd0, Q_MIN, 1'b1);
    drain_results();
    write_coef(REG_DECAY, DECAY_RESET);
    write_coef(REG_GAIN, GAIN_RESET);
  endtask

  task automatic test_table_fill();
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_request(CMD_WEIGHT, i[IDX_W-1:0], pick_q16(), 1'($urandom_range(1)));
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n_items);
    int sent0;
    int len;
    int r;
    drain_results();
    write_coef(REG_DECAY, COEF_W'($urandom_range(16'hFFFF)));
    write_coef(REG_GAIN, COEF_W'($urandom_range(16'hFFFF)));
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    sent0 = weight_reqs + activity_reqs;
    while (weight_reqs + activity_reqs - sent0 < n_items) begin
      r = $urandom_range(99);
      if (r < 2) begin
        drain_results();
      end else if (r < 10) begin
        send_request(CMD_WEIGHT, IDX_W'($urandom_range(255)), pick_q16(),
                     1'($urandom_range(1)));
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(48, 7) : $urandom_range(6, 1);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(19) == 0)
            send_request(CMD_WEIGHT, IDX_W'($urandom_range(255)), pick_q16(),
                         1'($urandom_range(1)));
          send_request(CMD_ACTIVITY, IDX_W'($urandom_range(255)), pick_q16(), k == len - 1);
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_rounding_and_saturation();
    test_coefficient_extremes();
    test_table_fill();
    test_random_traffic(16, 77, 300);
    test_random_traffic(77, 16, 300);
    test_random_traffic(0, 0, 300);
    drain_results();
    $display("Run covered %0d weight and %0d activity requests, %0d readouts checked,",
             weight_reqs, activity_reqs, readouts_checked);
    $display("with %0d coefficient writes across three handshake pressure phases.",
             coef_writes);
    if (failures == 0 && pending_readouts.size() == 0) begin
      $display("[weighted_readout_lowpass_top] OK");
    end else begin
      $display("[weighted_readout_lowpass_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/wrl_pkg.sv
rtl/core/wrl_ctrl.sv
rtl/core/wrl_dp.sv
rtl/core/weighted_readout_lowpass_top.sv
tb/sv/weighted_readout_lowpass_top_tb.sv
